@@ sv/mstt_pkg.sv @@
// Package for the countdown timer table: item types, codes and control bundles.
`timescale 1ns / 1ps

package mstt_pkg;

  // Default number of timer slots.
  localparam int SLOT_COUNT_DEF = 16;

  // A single tick reports at most this many expiries.
  localparam int MAX_RESULTS = 16;

  // Request action codes.
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  slot_index;
    logic [31:0] duration;
    logic [15:0] callback_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  slot_number;
    logic [15:0] expired_tag;
    logic        status;
    logic        last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic add_step;
    logic rem_do;
    logic tick_issue;
    logic tick_flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic idx_last;
  } stat_t;

endpackage

@@ sv/mstt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mstt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mstt_dpath.sv @@
// Datapath of the timer table: slot state, scan index, timer memories and result register.
`timescale 1ns / 1ps

module mstt_dpath #(
  parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  mstt_pkg::req_t      request,
  input  mstt_pkg::cmd_t      cmd,
  output mstt_pkg::stat_t     stat,
  output mstt_pkg::res_t      result,
  output logic                result_valid
);

  localparam int N_W = $clog2(mstt_pkg::MAX_RESULTS + 1);

  typedef logic [IDX_W-1:0] idx_t;

  mstt_pkg::req_t  req;
  logic [SLOT_COUNT-1:0] active;
  idx_t            idx;
  logic            eval_valid;
  idx_t            eval_idx;
  logic [N_W-1:0]  n_emit;
  logic            pend_valid;
  logic [3:0]      pend_slot;
  logic [15:0]     pend_tag;

  logic            ram_we;
  idx_t            ram_waddr;
  logic [31:0]     ticks_wdata;
  logic            tag_we;
  logic [31:0]     ticks_rdata;
  logic [15:0]     tag_rdata;

  logic            rem_null;
  idx_t            rem_idx;
  logic            eval_act;
  logic            eval_due;
  logic            eval_emit;

  assign stat.slot_free = ~active[idx];
  assign stat.idx_last  = (idx == idx_t'(SLOT_COUNT - 1));

  assign rem_null = ({2'b00, req.slot_index} >= 7'(SLOT_COUNT));
  assign rem_idx  = idx_t'(req.slot_index);

  assign eval_act  = eval_valid & active[eval_idx];
  assign eval_due  = (ticks_rdata <= 32'd1);
  assign eval_emit = eval_act & eval_due & (n_emit < N_W'(mstt_pkg::MAX_RESULTS));

  // Memory write port: add stores the new duration; a tick writes back the count.
  always_comb begin
    ram_we      = 1'b0;
    tag_we      = 1'b0;
    ram_waddr   = idx;
    ticks_wdata = req.duration;
    if (cmd.add_step && !active[idx]) begin
      ram_we = 1'b1;
      tag_we = 1'b1;
    end else if (eval_act && !eval_emit) begin
      ram_we      = 1'b1;
      ram_waddr   = eval_idx;
      ticks_wdata = eval_due ? 32'd0 : (ticks_rdata - 32'd1);
    end
  end

  mstt_ram #(
    .WIDTH (32),
    .DEPTH (SLOT_COUNT)
  ) u_ticks_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ticks_wdata),
    .raddr (idx),
    .rdata (ticks_rdata)
  );

  mstt_ram #(
    .WIDTH (16),
    .DEPTH (SLOT_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (idx),
    .wdata (req.callback_tag),
    .raddr (idx),
    .rdata (tag_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      eval_valid   <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      idx          <= '0;
      n_emit       <= '0;
    end else begin
      result_valid <= 1'b0;
      eval_valid   <= cmd.tick_issue;
      if (cmd.load) begin
        idx        <= '0;
        n_emit     <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.add_step) begin
        if (!active[idx]) begin
          active[idx]  <= 1'b1;
          result_valid <= 1'b1;
        end else if (stat.idx_last) begin
          result_valid <= 1'b1;
        end else begin
          idx <= idx + idx_t'(1);
        end
      end
      if (cmd.rem_do) begin
        result_valid <= 1'b1;
        if (!rem_null) begin
          active[rem_idx] <= 1'b0;
        end
      end
      if (cmd.tick_issue && !stat.idx_last) begin
        idx <= idx + idx_t'(1);
      end
      if (eval_emit) begin
        active[eval_idx] <= 1'b0;
        n_emit           <= n_emit + N_W'(1);
        pend_valid       <= 1'b1;
        if (pend_valid) begin
          result_valid <= 1'b1;
        end
      end
      if (cmd.tick_flush) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          result_valid <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
    if (cmd.tick_issue) begin
      eval_idx <= idx;
    end
    if (cmd.add_step) begin
      result.result_kind <= mstt_pkg::KIND_ADD;
      result.expired_tag <= 16'd0;
      result.last        <= 1'b1;
      if (!active[idx]) begin
        result.slot_number <= 4'(idx);
        result.status      <= 1'b0;
      end else begin
        result.slot_number <= 4'd0;
        result.status      <= 1'b1;
      end
    end
    if (cmd.rem_do) begin
      result.result_kind <= mstt_pkg::KIND_REMOVE;
      result.slot_number <= 4'd0;
      result.expired_tag <= 16'd0;
      result.status      <= rem_null;
      result.last        <= 1'b1;
    end
    if (eval_emit) begin
      pend_slot <= 4'(eval_idx);
      pend_tag  <= tag_rdata;
      result.result_kind <= mstt_pkg::KIND_EXPIRY;
      result.slot_number <= pend_slot;
      result.expired_tag <= pend_tag;
      result.status      <= 1'b0;
      result.last        <= 1'b0;
    end
    if (cmd.tick_flush) begin
      result.result_kind <= mstt_pkg::KIND_EXPIRY;
      result.slot_number <= pend_slot;
      result.expired_tag <= pend_tag;
      result.status      <= 1'b0;
      result.last        <= 1'b1;
    end
  end

endmodule

@@ sv/mstt_ctrl.sv @@
// Controller of the timer table: sequences add, remove and tick items.
`timescale 1ns / 1ps

module mstt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      action,
  input  mstt_pkg::stat_t stat,
  output mstt_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_REMOVE,
    S_TICK_SCAN,
    S_TICK_WAIT,
    S_TICK_FLUSH
  } state_t;

  state_t state;

  always_comb begin
    cmd            = '0;
    cmd.load       = start & ~busy;
    cmd.add_step   = (state == S_ADD_SCAN);
    cmd.rem_do     = (state == S_REMOVE);
    cmd.tick_issue = (state == S_TICK_SCAN);
    cmd.tick_flush = (state == S_TICK_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (action)
              mstt_pkg::ACT_ADD: begin
                state <= S_ADD_SCAN;
                busy  <= 1'b1;
              end
              mstt_pkg::ACT_REMOVE: begin
                state <= S_REMOVE;
                busy  <= 1'b1;
              end
              mstt_pkg::ACT_TICK: begin
                state <= S_TICK_SCAN;
                busy  <= 1'b1;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD_SCAN: begin
          if (stat.slot_free || stat.idx_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_REMOVE: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        S_TICK_SCAN: begin
          if (stat.idx_last) begin
            state <= S_TICK_WAIT;
          end
        end
        S_TICK_WAIT: begin
          state <= S_TICK_FLUSH;
        end
        S_TICK_FLUSH: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ sv/multi_slot_countdown_timer_table.sv @@
// Top level of the multi-slot countdown timer table.
`timescale 1ns / 1ps

// A table of SLOT_COUNT one-shot countdown timers driven by request items.
// A request item is taken at a rising edge where start is high and busy is
// low. Add takes the lowest free slot, remove frees a named slot, and tick
// counts every active timer down, reporting each timer that runs out.
// Every result item appears on result for exactly one cycle, marked by
// result_valid; the receiver cannot stall, so results are never held back.
// The final result caused by one request item carries last.
// Sequence of each item, from the accepting edge to the result register:
//   add:    the scan starts at slot 0 and stops at the first free slot,
//           or at the last slot when full; the result is registered and
//           busy drops at the same edge.
//   remove: the remove state registers the result and drops busy.
//   tick:   a wait state and a flush state follow the scan. Expiry
//           results come out as the scan runs, each held back until the
//           next is found; the flush state registers the last, if any.
// The scan runs at one slot per cycle, paced by the single read port of the
// count and tag memories. An item whose action code is unused yields no
// result and keeps busy low. Synchronous reset frees every slot and drops
// busy and result_valid; the memories need no clearing.
module multi_slot_countdown_timer_table #(
  parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mstt_pkg::req_t request,
  output mstt_pkg::res_t result,
  output logic           result_valid
);

  mstt_pkg::cmd_t  cmd;
  mstt_pkg::stat_t stat;

  // The controller walks through the steps of each item.
  mstt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (request.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the slot table and builds the result items.
  mstt_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the multi-slot countdown timer table.
`timescale 1ns / 1ps

// The bench drives request items through the start/busy handshake. It keeps
// its own copy of the timer table and predicts every result item that each
// accepted item should cause. A checker process compares each result item,
// field by field, with the oldest prediction. Inputs change on the falling
// edge and outputs are sampled on the rising edge, so that no check depends
// on the order of events within a time step.
module tb_top;

  localparam int SLOTS = mstt_pkg::SLOT_COUNT_DEF;
  localparam int RANDOM_ITEMS = 200;

  // The slowest legal run is roughly 230 items, each one busy for at most
  // a tick with its full scan and followed by a random idle gap. The limit
  // allows many times the length of such a run.
  localparam int CYCLE_LIMIT = 200000;

  // The fourth action code has no meaning. The block must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  mstt_pkg::req_t request = '0;
  logic busy;
  mstt_pkg::res_t result;
  logic result_valid;

  multi_slot_countdown_timer_table #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result(result),
    .result_valid(result_valid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // This is the bench's own copy of the timer table. Counts and tags are
  // read only for active slots, so their starting values do not matter.
  logic        slot_busy_model [SLOTS];
  logic [31:0] ticks_model [SLOTS];
  logic [15:0] tag_model [SLOTS];

  // These are the predicted result items, oldest first.
  mstt_pkg::res_t pending_results[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;

  // Update the table copy for one accepted item, and queue the result
  // items that the item should produce.
  task automatic predict_timer_table(input mstt_pkg::req_t item);
    mstt_pkg::res_t reply;
    int   due[$];
    bit   granted;
    reply = '0;
    granted = 1'b0;
    case (item.action)
      mstt_pkg::ACT_ADD: begin
        // Add takes the lowest free slot. When every slot is taken, the
        // reply carries a full status and the table is left alone.
        reply.result_kind = mstt_pkg::KIND_ADD;
        reply.last = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!granted && !slot_busy_model[i]) begin
            granted = 1'b1;
            slot_busy_model[i] = 1'b1;
            ticks_model[i] = item.duration;
            tag_model[i] = item.callback_tag;
            reply.slot_number = i[3:0];
          end
        end
        reply.status = !granted;
        pending_results.push_back(reply);
      end
      mstt_pkg::ACT_REMOVE: begin
        // An index past the table stands for the null slot and gets an
        // error status. Removing a slot that is already free is harmless.
        reply.result_kind = mstt_pkg::KIND_REMOVE;
        reply.last = 1'b1;
        if (item.slot_index >= SLOTS) begin
          reply.status = 1'b1;
        end else begin
          slot_busy_model[item.slot_index] = 1'b0;
        end
        pending_results.push_back(reply);
      end
      mstt_pkg::ACT_TICK: begin
        // A slot whose count would reach zero or below expires and is freed.
        // The expiry cap never takes effect with the default table size, but
        // it is kept here so that the prediction stays faithful.
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy_model[i]) begin
            if (ticks_model[i] <= 32'd1) begin
              if (due.size() < mstt_pkg::MAX_RESULTS) begin
                due.push_back(i);
                slot_busy_model[i] = 1'b0;
              end else begin
                ticks_model[i] = '0;
              end
            end else begin
              ticks_model[i] = ticks_model[i] - 32'd1;
            end
          end
        end
        // A tick with nothing due produces no result item.
        for (int j = 0; j < due.size(); j++) begin
          reply = '0;
          reply.result_kind = mstt_pkg::KIND_EXPIRY;
          reply.slot_number = due[j][3:0];
          reply.expired_tag = tag_model[due[j]];
          reply.last = (j == due.size() - 1);
          pending_results.push_back(reply);
        end
      end
      default: begin
        // The unused action code leaves the table and the output untouched.
      end
    endcase
  endtask

  // Most gaps are short and a few are long. During a back-to-back stretch,
  // no gap is inserted.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Present one request item and hold it until the block takes it. The task
  // is entered on a falling edge and returns on one. When the next item
  // follows with no gap, start stays high, so it is never lowered and raised
  // again in the same step.
  task automatic send_item(input logic [1:0] action, input logic [4:0] slot,
                           input logic [31:0] dur, input logic [15:0] tag);
    mstt_pkg::req_t item;
    int   gap;
    item.action = action;
    item.slot_index = slot;
    item.duration = dur;
    item.callback_tag = tag;
    request <= item;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_table(item);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // The receiver cannot stall, so every cycle with result_valid high is
  // exactly one result item to check.
  always @(posedge clk) begin
    mstt_pkg::res_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing predicted: %p", result);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(result.result_kind));
        check_field("slot_number", 32'(want.slot_number), 32'(result.slot_number));
        check_field("expired_tag", 32'(want.expired_tag), 32'(result.expired_tag));
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("last", 32'(want.last), 32'(result.last));
      end
    end
  end

  // This is the watchdog. A hung handshake or a missing result item ends
  // the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_slot_countdown_timer_table regression: fail");
      $finish;
    end
  end

  // Basic add and remove with extreme tags and durations. The longest
  // duration is removed before it can expire. The zero duration expires on
  // the very next tick, and a second tick then finds nothing due.
  task automatic test_add_remove;
    send_item(mstt_pkg::ACT_ADD, 5'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(mstt_pkg::ACT_ADD, 5'd31, 32'd0, 16'h0000);
    send_item(mstt_pkg::ACT_REMOVE, 5'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(mstt_pkg::ACT_REMOVE, 5'd15, 32'd0, 16'd0);
    send_item(mstt_pkg::ACT_TICK, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(mstt_pkg::ACT_TICK, 5'd0, 32'd0, 16'd0);
  endtask

  // A remove with an index at or past the table size is a null slot.
  task automatic test_null_remove;
    send_item(mstt_pkg::ACT_REMOVE, 5'd16, 32'd0, 16'd0);
    send_item(mstt_pkg::ACT_REMOVE, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_unused_action;
    send_item(ACT_UNUSED, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // Fill every slot and ask for one more, which must report a full table.
  // Every count is zero or one, so a single tick then expires all sixteen
  // slots at once, and only the final expiry carries last.
  task automatic test_table_full;
    for (int i = 0; i < SLOTS; i++) begin
      send_item(mstt_pkg::ACT_ADD, 5'd0, 32'(i % 2), 16'($urandom_range(0, 65535)));
    end
    send_item(mstt_pkg::ACT_ADD, 5'd0, 32'd1, 16'hA5A5);
    send_item(mstt_pkg::ACT_TICK, 5'd0, 32'd0, 16'd0);
  endtask

  // Random traffic. Durations are mostly short, so slots expire and get
  // reused. A few durations are huge and hold a slot until a remove frees
  // it. Back-to-back stretches, chosen at random, mix with stretches that
  // have random idle gaps.
  task automatic test_random_traffic;
    int         roll;
    logic [1:0] act;
    logic [4:0] slot;
    logic [31:0] dur;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 38) act = mstt_pkg::ACT_ADD;
      else if (roll < 58) act = mstt_pkg::ACT_REMOVE;
      else if (roll < 95) act = mstt_pkg::ACT_TICK;
      else act = ACT_UNUSED;
      slot = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                         : 5'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (act != mstt_pkg::ACT_ADD || roll >= 90) dur = $urandom;
      else if (roll < 70) dur = $urandom_range(0, 6);
      else dur = $urandom_range(7, 40);
      send_item(act, slot, dur, 16'($urandom_range(0, 65535)));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy_model[i] = 1'b0;
      ticks_model[i] = '0;
      tag_model[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_add_remove();
    test_null_remove();
    test_unused_action();
    test_table_full();
    test_random_traffic();

    // Drop start, wait for every predicted result item, and then allow one
    // more full scan so that any stray result item shows up.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);

    if (fail_count == 0) begin
      $display("multi_slot_countdown_timer_table regression: pass");
    end else begin
      $display("multi_slot_countdown_timer_table regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mstt_pkg.sv
sv/mstt_ram.sv
sv/mstt_dpath.sv
sv/mstt_ctrl.sv
sv/multi_slot_countdown_timer_table.sv
verif/tb_top.sv
